// ----- hw/rtl/dmsp_pkg.sv -----
// ============================================================================
// dmsp_pkg: shared definitions for the matrix shortest path engine
// Widths, register codes, controller states and the command and status
// structures that pass between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dmsp_pkg;

    localparam int MAX_NODES     = 64;
    localparam int NODE_BITS     = 6;
    localparam int COUNT_BITS    = 7;
    localparam int WEIGHT_BITS   = 16;
    localparam int DIST_BITS     = 24;
    localparam int ROUND_BITS    = 16;
    localparam int MAT_ADDR_BITS = 2 * NODE_BITS;
    localparam int MAT_DEPTH     = MAX_NODES * MAX_NODES;
    localparam int S_DATA_BITS   = 32;
    localparam int M_DATA_BITS   = 40;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [DIST_BITS-1:0]     DIST_MAX      = {DIST_BITS{1'b1}};
    localparam logic [MAT_ADDR_BITS-1:0] MAT_LAST_ADDR = {MAT_ADDR_BITS{1'b1}};

    localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET  = 7'd64;
    localparam logic [ROUND_BITS-1:0] ROUND_LIMIT_RESET = 16'd64;

    // Register word index (address bit 2).
    localparam logic REG_NODE_COUNT  = 1'b0;
    localparam logic REG_ROUND_LIMIT = 1'b1;

    // Item operation codes.
    localparam logic OPN_WRITE_LINK = 1'b0;
    localparam logic OPN_RUN        = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_ROUND,
        ST_SEL_SCAN,
        ST_SEL_DONE,
        ST_SEL_APPLY,
        ST_FETCH,
        ST_FETCH_WAIT,
        ST_RELAX,
        ST_RELAX_DRAIN,
        ST_OUT_READ,
        ST_OUT_LOAD
    } state_t;

    // Operation issued together with a node table read; acted on together with the registered read data.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SEL,
        OP_FETCH,
        OP_RELAX,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t                   op;
        logic [NODE_BITS-1:0]     idx;
        logic                     init;
        logic                     sel_clear;
        logic                     sel_apply;
        logic                     link_wr;
        logic                     clr_wr;
        logic [MAT_ADDR_BITS-1:0] clr_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic target;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]  n_last;
        logic [ROUND_BITS-1:0] round_limit;
    } cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dmsp_regs.sv -----
// ============================================================================
// dmsp_regs: configuration registers
// Holds the node count and the round limit behind a simple APB slave.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dmsp_regs
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic                                  paddr_word,
    input  wire logic [dmsp_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic      [dmsp_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                       pready,
    output dmsp_pkg::cfg_t                             cfg
);

    logic [dmsp_pkg::COUNT_BITS-1:0] node_count_reg;
    logic [dmsp_pkg::ROUND_BITS-1:0] round_limit_reg;
    logic                            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= dmsp_pkg::NODE_COUNT_RESET;
            round_limit_reg <= dmsp_pkg::ROUND_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            if (paddr_word == dmsp_pkg::REG_NODE_COUNT)
            begin
                node_count_reg <= pwdata[dmsp_pkg::COUNT_BITS-1:0];
            end
            else
            begin
                round_limit_reg <= pwdata[dmsp_pkg::ROUND_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr_word == dmsp_pkg::REG_NODE_COUNT)
        begin
            prdata = {{(dmsp_pkg::APB_DATA_BITS-dmsp_pkg::COUNT_BITS){1'b0}}, node_count_reg};
        end
        else
        begin
            prdata = {{(dmsp_pkg::APB_DATA_BITS-dmsp_pkg::ROUND_BITS){1'b0}}, round_limit_reg};
        end
    end

    // Node count clamped to 2..64, expressed as the index of the last node.
    always_comb
    begin
        if (node_count_reg < 7'd2)
        begin
            cfg.n_last = 6'd1;
        end
        else if (node_count_reg > 7'(dmsp_pkg::MAX_NODES))
        begin
            cfg.n_last = 6'(dmsp_pkg::MAX_NODES - 1);
        end
        else
        begin
            cfg.n_last = 6'(node_count_reg - 7'd1);
        end
        cfg.round_limit = round_limit_reg;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dmsp_ctrl.sv -----
// ============================================================================
// dmsp_ctrl: sequencing state machine
// Steps through matrix clearing, link writes, search rounds and result output.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dmsp_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tuser,
    output logic                      s_tready,
    input  wire dmsp_pkg::cfg_t       cfg,
    input  wire dmsp_pkg::dp_status_t status,
    output dmsp_pkg::dp_cmd_t         cmd
);

    dmsp_pkg::state_t                   state_reg, state_next;
    logic [dmsp_pkg::NODE_BITS-1:0]     idx_reg, idx_next;
    logic [dmsp_pkg::ROUND_BITS-1:0]    round_reg, round_next;
    logic [dmsp_pkg::MAT_ADDR_BITS-1:0] clr_reg, clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmsp_pkg::ST_CLEAR;
            idx_reg   <= '0;
            round_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            round_reg <= round_next;
            clr_reg   <= clr_next;
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        round_next = round_reg;
        clr_next   = clr_reg;
        case (state_reg)
            dmsp_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == dmsp_pkg::MAT_LAST_ADDR)
                begin
                    state_next = dmsp_pkg::ST_IDLE;
                end
            end
            dmsp_pkg::ST_IDLE:
            begin
                if (s_tvalid && (s_tuser == dmsp_pkg::OPN_RUN))
                begin
                    state_next = dmsp_pkg::ST_INIT;
                end
            end
            dmsp_pkg::ST_INIT:
            begin
                round_next = '0;
                state_next = dmsp_pkg::ST_ROUND;
            end
            dmsp_pkg::ST_ROUND:
            begin
                if (status.target || (round_reg == cfg.round_limit))
                begin
                    idx_next   = '0;
                    state_next = dmsp_pkg::ST_OUT_READ;
                end
                else
                begin
                    idx_next   = cfg.n_last;
                    state_next = dmsp_pkg::ST_SEL_SCAN;
                end
            end
            dmsp_pkg::ST_SEL_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    state_next = dmsp_pkg::ST_SEL_DONE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            dmsp_pkg::ST_SEL_DONE:
            begin
                state_next = dmsp_pkg::ST_SEL_APPLY;
            end
            dmsp_pkg::ST_SEL_APPLY:
            begin
                state_next = dmsp_pkg::ST_FETCH;
            end
            dmsp_pkg::ST_FETCH:
            begin
                state_next = dmsp_pkg::ST_FETCH_WAIT;
            end
            dmsp_pkg::ST_FETCH_WAIT:
            begin
                idx_next   = '0;
                state_next = dmsp_pkg::ST_RELAX;
            end
            dmsp_pkg::ST_RELAX:
            begin
                if (idx_reg == cfg.n_last)
                begin
                    state_next = dmsp_pkg::ST_RELAX_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            dmsp_pkg::ST_RELAX_DRAIN:
            begin
                round_next = round_reg + 1'b1;
                state_next = dmsp_pkg::ST_ROUND;
            end
            dmsp_pkg::ST_OUT_READ:
            begin
                if (!status.out_busy)
                begin
                    state_next = dmsp_pkg::ST_OUT_LOAD;
                end
            end
            dmsp_pkg::ST_OUT_LOAD:
            begin
                if (idx_reg == cfg.n_last)
                begin
                    state_next = dmsp_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = dmsp_pkg::ST_OUT_READ;
                end
            end
            default:
            begin
                state_next = dmsp_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.op        = dmsp_pkg::OP_NONE;
        cmd.idx       = idx_reg;
        cmd.clr_addr  = clr_reg;
        s_tready      = 1'b0;
        case (state_reg)
            dmsp_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            dmsp_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.link_wr = s_tvalid && (s_tuser == dmsp_pkg::OPN_WRITE_LINK);
            end
            dmsp_pkg::ST_INIT:
            begin
                cmd.init = 1'b1;
            end
            dmsp_pkg::ST_ROUND:
            begin
                cmd.sel_clear = 1'b1;
            end
            dmsp_pkg::ST_SEL_SCAN:
            begin
                cmd.op = dmsp_pkg::OP_SEL;
            end
            dmsp_pkg::ST_SEL_APPLY:
            begin
                cmd.sel_apply = 1'b1;
            end
            dmsp_pkg::ST_FETCH:
            begin
                cmd.op = dmsp_pkg::OP_FETCH;
            end
            dmsp_pkg::ST_RELAX:
            begin
                cmd.op = dmsp_pkg::OP_RELAX;
            end
            dmsp_pkg::ST_OUT_READ:
            begin
                if (!status.out_busy)
                begin
                    cmd.op = dmsp_pkg::OP_OUT;
                end
            end
            default:
            begin
                cmd.op = dmsp_pkg::OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dmsp_dp.sv -----
// ============================================================================
// dmsp_dp: search datapath
// Link matrix memory, node distance and predecessor memories, node flags,
// minimum selection, relaxation and the output word register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dmsp_dp
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dmsp_pkg::dp_cmd_t                   cmd,
    input  wire dmsp_pkg::cfg_t                      cfg,
    input  wire logic [dmsp_pkg::S_DATA_BITS-1:0]    s_tdata,
    output logic      [dmsp_pkg::M_DATA_BITS-1:0]    m_tdata,
    output logic                                     m_tvalid,
    output logic                                     m_tlast,
    input  wire logic                                m_tready,
    output dmsp_pkg::dp_status_t                     status
);

    localparam int NB = dmsp_pkg::NODE_BITS;
    localparam int DB = dmsp_pkg::DIST_BITS;
    localparam int WB = dmsp_pkg::WEIGHT_BITS;
    localparam int AB = dmsp_pkg::MAT_ADDR_BITS;

    logic [WB-1:0] mat_mem  [0:dmsp_pkg::MAT_DEPTH-1];
    logic [DB-1:0] dist_mem [0:dmsp_pkg::MAX_NODES-1];
    logic [NB-1:0] pred_mem [0:dmsp_pkg::MAX_NODES-1];

    logic [WB-1:0] mat_rd_reg;
    logic [DB-1:0] dist_rd_reg;
    logic [NB-1:0] pred_rd_reg;

    dmsp_pkg::dp_op_t             op_q_reg;
    logic [NB-1:0]                idx_q_reg;
    logic [dmsp_pkg::MAX_NODES-1:0] reached_reg;
    logic [dmsp_pkg::MAX_NODES-1:0] explored_reg;
    logic                         target_reg;
    logic [NB-1:0]                current_reg;
    logic                         have_reg;
    logic [NB-1:0]                best_reg;
    logic [DB-1:0]                best_dist_reg;
    logic [DB-1:0]                dist_f_reg;

    logic                         out_valid_reg;
    logic [NB-1:0]                out_node_reg;
    logic [DB-1:0]                out_dist_reg;
    logic [NB-1:0]                out_pred_reg;
    logic                         out_reached_reg;
    logic                         out_target_reg;
    logic                         out_last_reg;

    logic          mat_we;
    logic [AB-1:0] mat_waddr;
    logic [WB-1:0] mat_wdata;
    logic [AB-1:0] mat_raddr;
    logic [NB-1:0] node_raddr;
    logic          node_we;
    logic [NB-1:0] node_waddr;
    logic [DB-1:0] node_wdist;
    logic [NB-1:0] node_wpred;
    logic [DB:0]   sum_wide;
    logic [DB-1:0] sum_sat;
    logic          relax_upd;
    logic          sel_better;

    // Matrix write: link writes from the input word, zeros during the clearing pass.
    always_comb
    begin
        mat_we    = cmd.clr_wr | cmd.link_wr;
        mat_waddr = cmd.clr_wr ? cmd.clr_addr : {s_tdata[NB-1:0], s_tdata[2*NB-1:NB]};
        mat_wdata = cmd.clr_wr ? '0 : s_tdata[2*NB+WB-1:2*NB];
        mat_raddr = {current_reg, cmd.idx};
        node_raddr = (cmd.op == dmsp_pkg::OP_FETCH) ? current_reg : cmd.idx;
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        mat_rd_reg <= mat_mem[mat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            dist_mem[node_waddr] <= node_wdist;
            pred_mem[node_waddr] <= node_wpred;
        end
        dist_rd_reg <= dist_mem[node_raddr];
        pred_rd_reg <= pred_mem[node_raddr];
    end

    // Relaxation of one link from the explored node, with saturation.
    always_comb
    begin
        sum_wide  = {1'b0, dist_f_reg} + {{(DB+1-WB){1'b0}}, mat_rd_reg};
        sum_sat   = sum_wide[DB] ? dmsp_pkg::DIST_MAX : sum_wide[DB-1:0];
        relax_upd = (op_q_reg == dmsp_pkg::OP_RELAX) && (mat_rd_reg != '0)
                    && (!reached_reg[idx_q_reg] || (sum_sat < dist_rd_reg));
        sel_better = (op_q_reg == dmsp_pkg::OP_SEL) && !explored_reg[idx_q_reg]
                     && reached_reg[idx_q_reg]
                     && (!have_reg || (dist_rd_reg < best_dist_reg));
        node_we    = cmd.init | relax_upd;
        node_waddr = cmd.init ? '0 : idx_q_reg;
        node_wdist = cmd.init ? '0 : sum_sat;
        node_wpred = cmd.init ? '0 : current_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_q_reg      <= dmsp_pkg::OP_NONE;
            idx_q_reg     <= '0;
            reached_reg   <= '0;
            explored_reg  <= '0;
            target_reg    <= 1'b0;
            current_reg   <= '0;
            have_reg      <= 1'b0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_q_reg  <= cmd.op;
            idx_q_reg <= cmd.idx;
            if (cmd.init)
            begin
                reached_reg  <= {{(dmsp_pkg::MAX_NODES-1){1'b0}}, 1'b1};
                explored_reg <= '0;
                target_reg   <= 1'b0;
                current_reg  <= '0;
            end
            if (relax_upd)
            begin
                reached_reg[idx_q_reg] <= 1'b1;
            end
            if (cmd.sel_clear)
            begin
                have_reg <= 1'b0;
            end
            else if (sel_better)
            begin
                have_reg <= 1'b1;
                best_reg <= idx_q_reg;
            end
            if (cmd.sel_apply && have_reg)
            begin
                current_reg           <= best_reg;
                explored_reg[best_reg] <= 1'b1;
                if (best_reg == cfg.n_last)
                begin
                    target_reg <= 1'b1;
                end
            end
            if (op_q_reg == dmsp_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_better)
        begin
            best_dist_reg <= dist_rd_reg;
        end
        if (op_q_reg == dmsp_pkg::OP_FETCH)
        begin
            dist_f_reg <= dist_rd_reg;
        end
        if (op_q_reg == dmsp_pkg::OP_OUT)
        begin
            out_node_reg    <= idx_q_reg;
            out_reached_reg <= reached_reg[idx_q_reg];
            out_dist_reg    <= reached_reg[idx_q_reg] ? dist_rd_reg : '0;
            out_pred_reg    <= reached_reg[idx_q_reg] ? pred_rd_reg : '0;
            out_target_reg  <= target_reg;
            out_last_reg    <= (idx_q_reg == cfg.n_last);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_target_reg, out_reached_reg, out_pred_reg,
                       out_dist_reg, out_node_reg};

    assign status.target   = target_reg;
    assign status.out_busy = out_valid_reg & ~m_tready;

endmodule

`default_nettype wire

// ----- hw/rtl/dijkstra_matrix_shortest_path_top.sv -----
// ============================================================================
// dijkstra_matrix_shortest_path_top: shortest path engine over a link matrix
// Array form of Dijkstra's algorithm from node 0 with per-node result words.
// ============================================================================
// After reset the block clears the 64 by 64 link matrix, one entry a cycle,
// and accepts no input word until that pass is over; configuration writes
// are taken throughout. An input word with tuser low writes one link weight
// (zero removes the link), and link words may stream in back to back. An input
// word with tuser high starts a search from node 0. A search begins with a
// set-up step and then runs selection rounds, where n is the clamped node
// count: one pass over n nodes through the distance memory finds the
// unexplored reached node of smallest distance (ties go to the higher index),
// and a second pass over n nodes reads that node's row of the link matrix and
// relaxes every link. Both passes are limited by the single read port of each
// memory. Rounds stop when the last node has been explored or the round limit
// is reached. One result word per node then follows, each waiting in an
// output register until taken, and the next is read only once that register
// is free or being taken; tlast marks the final node. The next input word is
// accepted as soon as the final result has been loaded, even while it still
// waits to be taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dijkstra_matrix_shortest_path_top
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input stream.
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // tdata: from_node[5:0], to_node[11:6], link_weight[27:12], zero pad [31:28]
    input  wire logic [dmsp_pkg::S_DATA_BITS-1:0]     s_tdata,
    // tuser: operation[0] (0 writes a link, 1 runs the search)
    input  wire logic                                 s_tuser,
    // Result stream.
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // tdata: node_index[5:0], path_distance[29:6], predecessor[35:30],
    //        reached[36], target_found[37], zero pad [39:38]
    output logic      [dmsp_pkg::M_DATA_BITS-1:0]     m_tdata,
    // tlast: last_item, set on the word for the final node.
    output logic                                      m_tlast,
    // Configuration port: node_count at 0x0, round_limit at 0x4.
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [dmsp_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [dmsp_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [dmsp_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                      pready
);

    dmsp_pkg::cfg_t       cfg;
    dmsp_pkg::dp_cmd_t    cmd;
    dmsp_pkg::dp_status_t status;

    // The register is selected by the word address; byte offset bits are ignored.
    dmsp_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr_word (paddr[2]),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cfg        (cfg)
    );

    // The controller owns all sequencing; the datapath only obeys commands.
    dmsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .cfg      (cfg),
        .status   (status),
        .cmd      (cmd)
    );

    dmsp_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tready (m_tready),
        .status   (status)
    );

`ifndef ASSERT_OFF
    // A link write and a clearing write never compete for the matrix port.
    a_single_mat_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.link_wr && cmd.clr_wr))
        else $error("link write during the matrix clearing pass");

    // While the datapath is reading node state, no input word is taken.
    a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != dmsp_pkg::OP_NONE) |-> !s_tready)
        else $error("input accepted while a search is in progress");

    // A run command closes the input for at least the next cycle.
    a_run_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == dmsp_pkg::OPN_RUN)) |=> !s_tready)
        else $error("input still open after a run command");

    // A result is only loaded when the output register is free.
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == dmsp_pkg::OP_OUT) |=> !m_tvalid)
        else $error("result read issued while the output register was full");
`endif

endmodule

`default_nettype wire
